/* sv/toe_pkg.sv */
package toe_pkg;

  localparam int MaxNodesDef = 32;
  localparam int MaxEdgesDef = 128;
  localparam int NodeW = 5;
  localparam int CountW = 6;

  typedef struct packed {
    logic       op;
    logic [4:0] from_node;
    logic [4:0] to_node;
  } toe_in_t;

  typedef struct packed {
    logic [4:0] node;
    logic       is_summary;
    logic [5:0] ordered_count;
    logic       has_cycle;
    logic       edge_dropped;
    logic       last;
  } toe_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_DEG_RD,
    ST_DEG_WR,
    ST_SEED,
    ST_POP,
    ST_SCAN_RD,
    ST_SCAN_WR,
    ST_EMIT,
    ST_SUM
  } toe_state_t;

  localparam logic OpAdd = 1'b0;
  localparam logic OpRun = 1'b1;

endpackage

/* sv/topological_order_engine_core.sv */
// Edge add: the block stays idle, so start may follow on the next cycle.
// Run: clears the node in-degrees, walks the stored edges to count in-degrees, seeds ready
// nodes, then for each placed node scans the stored edges through the one edge store read port.
// Results come one per cycle at the end: nodes in reversed order, then the summary.
// The receiver cannot stall results; busy stays high until the summary has been sent.
// Synchronous active-low reset clears the stored edge count and the dropped-edge flag and sets node_count to 32.
module topological_order_engine_core
  import toe_pkg::*;
#(
  parameter int MaxNodes = MaxNodesDef,
  parameter int MaxEdges = MaxEdgesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  toe_in_t            in_word,
  output logic               out_strobe,
  output toe_out_t           out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CountW-1:0]  cfg_node_count
);

  localparam int EAW = $clog2(MaxEdges);
  localparam int ECW = $clog2(MaxEdges + 1);
  localparam int NAW = $clog2(MaxNodes);
  localparam int NCW = $clog2(MaxNodes + 1);

  toe_state_t state_r, state_nxt;
  logic [CountW-1:0] ncfg_r;
  logic [ECW-1:0] etot_r, etot_nxt;
  logic drop_r, drop_nxt;
  logic [ECW-1:0] eidx_r, eidx_nxt;
  logic [NCW-1:0] i_r, i_nxt;
  logic [NCW-1:0] head_r, head_nxt, tail_r, tail_nxt, cnt_r, cnt_nxt;
  logic [NodeW-1:0] v_r, v_nxt;

  logic [ECW-1:0] deg [MaxNodes];
  logic [NodeW-1:0] queue [MaxNodes];

  logic [NCW-1:0] n_use;
  logic [NodeW-1:0] e_src, e_dst;
  logic [EAW-1:0] rd_addr;
  logic add_ok, we;
  logic deg_we;
  logic [NAW-1:0] deg_idx;
  logic [ECW-1:0] deg_wd;
  logic q_we;
  logic [NAW-1:0] q_idx;
  logic [NodeW-1:0] q_wd;

  always_comb begin
    if (ncfg_r == '0) n_use = NCW'(1);
    else if (32'(ncfg_r) > MaxNodes) n_use = NCW'(MaxNodes);
    else n_use = NCW'(ncfg_r);
  end

  assign busy = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign add_ok = (32'(in_word.from_node) < 32'(n_use)) &&
                  (32'(in_word.to_node) < 32'(n_use)) && (32'(etot_r) < MaxEdges);
  assign we = (state_r == ST_IDLE) && start && (in_word.op == OpAdd) && add_ok;
  assign rd_addr = EAW'(eidx_r);

  toe_edge_mem #(.MaxEdges(MaxEdges), .AddrW(EAW)) u_mem (
    .clk(clk), .wr_en(we), .wr_addr(EAW'(etot_r)),
    .wr_src(in_word.from_node), .wr_dst(in_word.to_node),
    .rd_addr(rd_addr), .rd_src(e_src), .rd_dst(e_dst)
  );

  logic e_valid_deg, e_hit;
  assign e_valid_deg = (32'(e_src) < 32'(n_use)) && (32'(e_dst) < 32'(n_use));
  assign e_hit = (e_src == v_r) && (32'(e_dst) < 32'(n_use));

  always_comb begin
    state_nxt = state_r;
    etot_nxt = etot_r;
    drop_nxt = drop_r;
    eidx_nxt = eidx_r;
    i_nxt = i_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt = cnt_r;
    v_nxt = v_r;
    deg_we = 1'b0;
    deg_idx = '0;
    deg_wd = '0;
    q_we = 1'b0;
    q_idx = '0;
    q_wd = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_word.op == OpAdd) begin
            if (add_ok) etot_nxt = etot_r + ECW'(1);
            else drop_nxt = 1'b1;
          end else begin
            i_nxt = '0;
            state_nxt = ST_CLR;
          end
        end
      end
      ST_CLR: begin
        deg_we = 1'b1;
        deg_idx = NAW'(i_r);
        if (i_r == n_use - NCW'(1)) begin
          eidx_nxt = '0;
          state_nxt = (etot_r == '0) ? ST_SEED : ST_DEG_RD;
          i_nxt = '0;
          tail_nxt = '0;
        end else begin
          i_nxt = i_r + NCW'(1);
        end
      end
      ST_DEG_RD: state_nxt = ST_DEG_WR;
      ST_DEG_WR: begin
        if (e_valid_deg) begin
          deg_we = 1'b1;
          deg_idx = NAW'(e_dst);
          deg_wd = deg[NAW'(e_dst)] + ECW'(1);
        end
        if (eidx_r == etot_r - ECW'(1)) begin
          state_nxt = ST_SEED;
        end else begin
          eidx_nxt = eidx_r + ECW'(1);
          state_nxt = ST_DEG_RD;
        end
        i_nxt = '0;
        tail_nxt = '0;
      end
      ST_SEED: begin
        if (deg[NAW'(i_r)] == '0) begin
          q_we = 1'b1;
          q_idx = NAW'(tail_r);
          q_wd = NodeW'(i_r);
          tail_nxt = tail_r + NCW'(1);
        end
        if (i_r == n_use - NCW'(1)) begin
          head_nxt = '0;
          cnt_nxt = '0;
          state_nxt = ST_POP;
        end else begin
          i_nxt = i_r + NCW'(1);
        end
      end
      ST_POP: begin
        if (head_r < tail_r) begin
          v_nxt = queue[NAW'(head_r)];
          head_nxt = head_r + NCW'(1);
          cnt_nxt = cnt_r + NCW'(1);
          eidx_nxt = '0;
          if (etot_r != '0) state_nxt = ST_SCAN_RD;
        end else begin
          i_nxt = cnt_r;
          state_nxt = (cnt_r == '0) ? ST_SUM : ST_EMIT;
        end
      end
      ST_SCAN_RD: state_nxt = ST_SCAN_WR;
      ST_SCAN_WR: begin
        if (e_hit && deg[NAW'(e_dst)] != '0) begin
          deg_we = 1'b1;
          deg_idx = NAW'(e_dst);
          deg_wd = deg[NAW'(e_dst)] - ECW'(1);
          if (deg[NAW'(e_dst)] == ECW'(1)) begin
            q_we = 1'b1;
            q_idx = NAW'(tail_r);
            q_wd = e_dst;
            tail_nxt = tail_r + NCW'(1);
          end
        end
        if (eidx_r == etot_r - ECW'(1)) begin
          state_nxt = ST_POP;
        end else begin
          eidx_nxt = eidx_r + ECW'(1);
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_EMIT: begin
        i_nxt = i_r - NCW'(1);
        if (i_r == NCW'(1)) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        etot_nxt = '0;
        drop_nxt = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_strobe = 1'b0;
    out_word = '0;
    case (state_r)
      ST_EMIT: begin
        out_strobe = 1'b1;
        out_word.node = queue[NAW'(i_r - NCW'(1))];
      end
      ST_SUM: begin
        out_strobe = 1'b1;
        out_word.is_summary = 1'b1;
        out_word.ordered_count = CountW'(cnt_r);
        out_word.has_cycle = (cnt_r < n_use);
        out_word.edge_dropped = drop_r;
        out_word.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (deg_we) deg[deg_idx] <= deg_wd;
    if (q_we) queue[q_idx] <= q_wd;
    eidx_r <= eidx_nxt;
    i_r <= i_nxt;
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    cnt_r <= cnt_nxt;
    v_r <= v_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      etot_r <= '0;
      drop_r <= 1'b0;
      ncfg_r <= CountW'(32);
    end else begin
      state_r <= state_nxt;
      etot_r <= etot_nxt;
      drop_r <= drop_nxt;
      if (cfg_valid && cfg_ready) ncfg_r <= cfg_node_count;
    end
  end

endmodule

/* sv/toe_edge_mem.sv */
module toe_edge_mem
  import toe_pkg::*;
#(
  parameter int MaxEdges = MaxEdgesDef,
  parameter int AddrW = $clog2(MaxEdges)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [NodeW-1:0] wr_src,
  input  logic [NodeW-1:0] wr_dst,
  input  logic [AddrW-1:0] rd_addr,
  output logic [NodeW-1:0] rd_src,
  output logic [NodeW-1:0] rd_dst
);

  logic [2*NodeW-1:0] mem [MaxEdges];
  logic [2*NodeW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_src, wr_dst};
    end
    rd_r <= mem[rd_addr];
  end

  assign rd_src = rd_r[2*NodeW-1:NodeW];
  assign rd_dst = rd_r[NodeW-1:0];

endmodule

/* sv/toe_checker.sv */
module toe_checker
  import toe_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input toe_in_t  in_word,
  input logic     out_strobe,
  input toe_out_t out_word
);

  a_last_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_word.last == out_word.is_summary)) else $error("last mismatch");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result while idle");

  a_summary_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.last) |=> !busy) else $error("busy after summary");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.op == OpRun) |=> busy) else $error("run not taken");

endmodule

bind topological_order_engine_core toe_checker u_toe_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
  .out_strobe(out_strobe), .out_word(out_word)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import toe_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  toe_in_t in_word;
  logic out_strobe;
  toe_out_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [CountW-1:0] cfg_node_count;

  topological_order_engine_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_node_count(cfg_node_count)
  );

  toe_in_t pending_words[$];
  toe_out_t expected_words[$];
  int mismatches;
  int result_total;
  int run_total;
  int edge_word_total;
  longint cycle_count;
  int gap_left;
  logic cfg_pending;
  logic [CountW-1:0] cfg_value;

  logic [4:0] graph_src[MaxEdgesDef];
  logic [4:0] graph_dst[MaxEdgesDef];
  int graph_edges;
  logic graph_dropped;
  logic [5:0] count_reg;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int active_nodes();
    int n;
    n = int'(count_reg);
    if (n == 0) n = 1;
    if (n > MaxNodesDef) n = MaxNodesDef;
    return n;
  endfunction

  task automatic sort_graph_word(input toe_in_t w);
    int n;
    int deg[MaxNodesDef];
    int ready[MaxNodesDef];
    int order[MaxNodesDef];
    int head;
    int tail;
    int cnt;
    int v;
    int t;
    toe_out_t r;
    n = active_nodes();
    if (w.op == OpAdd) begin
      if (w.from_node >= n || w.to_node >= n || graph_edges >= MaxEdgesDef) begin
        graph_dropped = 1'b1;
      end else begin
        graph_src[graph_edges] = w.from_node;
        graph_dst[graph_edges] = w.to_node;
        graph_edges++;
      end
      return;
    end
    head = 0;
    tail = 0;
    cnt = 0;
    for (int i = 0; i < n; i++) deg[i] = 0;
    for (int e = 0; e < graph_edges; e++) begin
      if (graph_src[e] < n && graph_dst[e] < n) deg[graph_dst[e]]++;
    end
    for (int i = 0; i < n; i++) begin
      if (deg[i] == 0) ready[tail++] = i;
    end
    while (head < tail && head < MaxNodesDef) begin
      v = ready[head++];
      order[cnt++] = v;
      for (int e = 0; e < graph_edges; e++) begin
        t = graph_dst[e];
        if (graph_src[e] == v && t < n && deg[t] > 0) begin
          deg[t]--;
          if (deg[t] == 0 && tail < MaxNodesDef) ready[tail++] = t;
        end
      end
    end
    for (int i = cnt; i > 0; i--) begin
      r = '0;
      r.node = 5'(order[i - 1]);
      expected_words.push_back(r);
    end
    r = '0;
    r.is_summary = 1'b1;
    r.ordered_count = 6'(cnt);
    r.has_cycle = (cnt < n);
    r.edge_dropped = graph_dropped;
    r.last = 1'b1;
    expected_words.push_back(r);
    graph_edges = 0;
    graph_dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      sort_graph_word(in_word);
      if (in_word.op == OpRun) run_total++;
      else edge_word_total++;
      void'(pending_words.pop_front());
      start <= 1'b0;
      gap_left <= $urandom_range(0, 9);
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_words.size() > 0) begin
        start <= 1'b1;
        in_word <= pending_words[0];
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      count_reg = cfg_node_count;
      cfg_valid <= 1'b0;
      cfg_pending = 1'b0;
    end else if (rst_n && cfg_pending && !cfg_valid) begin
      cfg_valid <= 1'b1;
      cfg_node_count <= cfg_value;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && out_strobe) begin
      result_total++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_word);
      end else if (expected_words[0] !== out_word) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p got %p", expected_words[0], out_word);
        void'(expected_words.pop_front());
      end else begin
        void'(expected_words.pop_front());
      end
    end
    if (cycle_count > 2000000) begin
      $display("timeout");
      $display("topological_order_engine_core test failed");
      $finish;
    end
  end

  function automatic toe_in_t make_word(logic op, int f, int t);
    toe_in_t w;
    w.op = op;
    w.from_node = 5'(f);
    w.to_node = 5'(t);
    return w;
  endfunction

  task automatic drain_and_configure(input int value);
    while (pending_words.size() > 0 || start) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_value = 6'(value);
    cfg_pending = 1'b1;
    while (cfg_pending) @(posedge clk);
  endtask

  task automatic queue_random_graph(input int n, input int edges, input int noise);
    for (int e = 0; e < edges; e++) begin
      if ($urandom_range(0, 99) < noise)
        pending_words.push_back(make_word(OpAdd, $urandom_range(0, 31),
                                          $urandom_range(0, 31)));
      else if ($urandom_range(0, 3) != 0 && n > 1)
        pending_words.push_back(make_word(OpAdd, $urandom_range(0, n - 2), 0));
      else
        pending_words.push_back(make_word(OpAdd, $urandom_range(0, n - 1),
                                          $urandom_range(0, n - 1)));
    end
    pending_words.push_back(make_word(OpRun, $urandom_range(0, 31), $urandom_range(0, 31)));
  endtask

  task automatic queue_dag(input int n, input int edges);
    int a;
    int b;
    for (int e = 0; e < edges; e++) begin
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      if (a == b) pending_words.push_back(make_word(OpAdd, a, a));
      else if (a < b) pending_words.push_back(make_word(OpAdd, a, b));
      else pending_words.push_back(make_word(OpAdd, b, a));
    end
    pending_words.push_back(make_word(OpRun, 0, 0));
  endtask

  initial begin
    int sizes[6];
    int n;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_node_count = '0;
    cfg_pending = 1'b0;
    mismatches = 0;
    result_total = 0;
    run_total = 0;
    edge_word_total = 0;
    cycle_count = 0;
    graph_edges = 0;
    graph_dropped = 1'b0;
    count_reg = 6'd32;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pending_words.push_back(make_word(OpRun, 0, 0));
    pending_words.push_back(make_word(OpAdd, 0, 31));
    pending_words.push_back(make_word(OpAdd, 31, 0));
    pending_words.push_back(make_word(OpAdd, 5, 5));
    pending_words.push_back(make_word(OpAdd, 1, 2));
    pending_words.push_back(make_word(OpAdd, 1, 2));
    pending_words.push_back(make_word(OpRun, 31, 31));
    pending_words.push_back(make_word(OpAdd, 3, 4));
    pending_words.push_back(make_word(OpAdd, 10, 20));
    drain_and_configure(8);
    pending_words.push_back(make_word(OpAdd, 8, 1));
    pending_words.push_back(make_word(OpAdd, 7, 0));
    pending_words.push_back(make_word(OpRun, 0, 0));
    drain_and_configure(1);
    pending_words.push_back(make_word(OpAdd, 0, 0));
    pending_words.push_back(make_word(OpRun, 0, 0));
    pending_words.push_back(make_word(OpAdd, 0, 1));
    pending_words.push_back(make_word(OpRun, 0, 0));
    drain_and_configure(0);
    pending_words.push_back(make_word(OpRun, 0, 0));
    drain_and_configure(63);
    for (int e = 0; e < 130; e++)
      pending_words.push_back(make_word(OpAdd, e % 31, e % 31 + 1));
    pending_words.push_back(make_word(OpRun, 0, 0));

    sizes = '{4, 32, 6, 3, 16, 2};
    for (int phase = 0; phase < 6; phase++) begin
      drain_and_configure(sizes[phase]);
      n = sizes[phase];
      for (int g = 0; g < 4; g++) begin
        if ($urandom_range(0, 2) != 0) queue_dag(n, $urandom_range(0, 2 * n));
        else queue_random_graph(n, $urandom_range(0, n + 4), 15);
      end
      if (phase == 2) begin
        for (int e = 0; e < 5; e++)
          pending_words.push_back(make_word(OpAdd, $urandom_range(0, 5), $urandom_range(0, 5)));
      end
    end
    drain_and_configure(3);
    pending_words.push_back(make_word(OpRun, 0, 0));

    while (pending_words.size() > 0 || start) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d edge words and %0d sort runs, %0d results checked",
             edge_word_total, run_total, result_total);
    $display("node counts from 0 to 63 applied, including capacity overflow");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("topological_order_engine_core test passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_words.size());
      $display("topological_order_engine_core test failed");
    end
    $finish;
  end
endmodule
